// ===== sv/cjd_pkg.sv =====
// ----------------------------------------------------------------------------
// cjd_pkg: shared types and constants for the calendar to Julian day block
// Transaction payload structs, pipeline stage structs, status codes and the
// fixed-point constants of the conversion.
// ----------------------------------------------------------------------------
package cjd_pkg;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_MONTH  = 3'd1,
    ST_DAY    = 3'd2,
    ST_HOUR   = 3'd3,
    ST_MINUTE = 3'd4,
    ST_SECOND = 3'd5,
    ST_NANO   = 3'd6
  } status_t;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [5:0]         day_of_month;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [29:0]        nanosecond;
  } in_t;

  typedef struct packed {
    logic signed [23:0] julian_day_number;
    logic [46:0]        day_nanoseconds;
    logic [2:0]         status;
  } out_t;

  // After decode: adjusted year, month term, seconds of the day.
  typedef struct packed {
    logic signed [15:0] year_adj;
    logic [8:0]         mterm;
    logic [5:0]         day;
    logic               reform;
    logic [16:0]        sod;
    logic [29:0]        ns;
    status_t            status;
  } s1_t;

  // After the multipliers.
  typedef struct packed {
    logic signed [24:0] yq;
    logic [7:0]         cent;
    logic [8:0]         mterm;
    logic [5:0]         day;
    logic               reform;
    logic [46:0]        ns_sec;
    logic [29:0]        ns;
    status_t            status;
  } s2_t;

  // After the sums, before the day wrap.
  typedef struct packed {
    logic signed [24:0] jdn;
    logic [46:0]        tod;
    status_t            status;
  } s3_t;

  localparam logic [20:0] JD_EPOCH_OFFSET = 21'd1720994;
  localparam logic [29:0] NS_PER_SEC      = 30'd1000000000;
  localparam logic [29:0] NS_MAX          = 30'd999999999;
  localparam logic [46:0] NS_PER_DAY      = 47'd86400000000000;
  localparam logic [46:0] NS_HALF_DAY     = 47'd43200000000000;
  localparam logic [12:0] DIV100_MUL      = 13'd5243;
  localparam int          DIV100_SHIFT    = 19;
  localparam logic signed [15:0] REFORM_YEAR = 16'sd1582;
  localparam logic [3:0]  REFORM_MONTH    = 4'd10;
  localparam logic [5:0]  REFORM_DAY      = 6'd15;

  // floor(30.6001 * (m + 1)) with January and February taken as months
  // 13 and 14; indexed by the calendar month.
  function automatic logic [8:0] month_term(input logic [3:0] month);
    logic [8:0] t;
    case (month)
      4'd1:    t = 9'd428;
      4'd2:    t = 9'd459;
      4'd3:    t = 9'd122;
      4'd4:    t = 9'd153;
      4'd5:    t = 9'd183;
      4'd6:    t = 9'd214;
      4'd7:    t = 9'd244;
      4'd8:    t = 9'd275;
      4'd9:    t = 9'd306;
      4'd10:   t = 9'd336;
      4'd11:   t = 9'd367;
      4'd12:   t = 9'd397;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/cjd_decode.sv =====
// ----------------------------------------------------------------------------
// cjd_decode: first pipeline stage
// Checks the fields, moves January and February to the previous year, looks
// up the month term and forms the seconds of the day.
// ----------------------------------------------------------------------------
module cjd_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ld,
  input  logic          vld_i,
  input  cjd_pkg::in_t  d_i,
  output logic          vld_r,
  output cjd_pkg::s1_t  d_r
);
  import cjd_pkg::*;

  s1_t                d_nxt;
  logic               early;
  logic signed [15:0] yext;
  logic [3:0]         m_adj;

  always_comb begin
    d_nxt = '0;
    if (d_i.month == 4'd0 || d_i.month > 4'd12) begin
      d_nxt.status = ST_MONTH;
    end else if (d_i.day_of_month == 6'd0) begin
      d_nxt.status = ST_DAY;
    end else if (d_i.hour > 5'd23) begin
      d_nxt.status = ST_HOUR;
    end else if (d_i.minute > 6'd59) begin
      d_nxt.status = ST_MINUTE;
    end else if (d_i.second > 6'd59) begin
      d_nxt.status = ST_SECOND;
    end else if (d_i.nanosecond > NS_MAX) begin
      d_nxt.status = ST_NANO;
    end else begin
      d_nxt.status = ST_OK;
    end

    early = (d_i.month < 4'd3);
    yext  = {d_i.year[14], d_i.year};
    m_adj = early ? d_i.month + 4'd12 : d_i.month;
    d_nxt.year_adj = early ? yext - 16'sd1 : yext;
    d_nxt.reform = (d_nxt.year_adj > REFORM_YEAR) ||
                   (d_nxt.year_adj == REFORM_YEAR &&
                    (m_adj > REFORM_MONTH ||
                     (m_adj == REFORM_MONTH && d_i.day_of_month >= REFORM_DAY)));
    d_nxt.mterm = month_term(d_i.month);
    d_nxt.day   = d_i.day_of_month;
    d_nxt.sod   = 17'(d_i.hour) * 17'd3600 + 17'(d_i.minute) * 17'd60 +
                  17'(d_i.second);
    d_nxt.ns    = d_i.nanosecond;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && vld_i) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== sv/cjd_mult.sv =====
// ----------------------------------------------------------------------------
// cjd_mult: second pipeline stage
// The three constant multiplications: 1461 * year (floored by four), the
// century by reciprocal multiplication, and seconds of the day to ns.
// ----------------------------------------------------------------------------
module cjd_mult (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ld,
  input  logic          vld_i,
  input  cjd_pkg::s1_t  d_i,
  output logic          vld_r,
  output cjd_pkg::s2_t  d_r
);
  import cjd_pkg::*;

  s2_t                d_nxt;
  logic signed [26:0] yprod;
  logic [26:0]        cprod;

  always_comb begin
    yprod = 27'(d_i.year_adj) * 27'sd1461;
    // Only used for reform years, where the year is positive and below 2^14.
    cprod = 27'(d_i.year_adj[13:0]) * 27'(DIV100_MUL);
    d_nxt.yq     = 25'(yprod >>> 2);
    d_nxt.cent   = 8'(cprod >> DIV100_SHIFT);
    d_nxt.mterm  = d_i.mterm;
    d_nxt.day    = d_i.day;
    d_nxt.reform = d_i.reform;
    d_nxt.ns_sec = 47'(d_i.sod) * 47'(NS_PER_SEC);
    d_nxt.ns     = d_i.ns;
    d_nxt.status = d_i.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && vld_i) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== sv/cjd_sum.sv =====
// ----------------------------------------------------------------------------
// cjd_sum: third pipeline stage
// Adds up the day count with the Gregorian correction and the time of day
// with the half-day offset.
// ----------------------------------------------------------------------------
module cjd_sum (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ld,
  input  logic          vld_i,
  input  cjd_pkg::s2_t  d_i,
  output logic          vld_r,
  output cjd_pkg::s3_t  d_r
);
  import cjd_pkg::*;

  s3_t                d_nxt;
  logic signed [24:0] corr;

  always_comb begin
    corr = d_i.reform ? 25'sd2 - $signed(25'(d_i.cent)) + $signed(25'(d_i.cent >> 2))
                      : 25'sd0;
    d_nxt.jdn = d_i.yq + $signed(25'(d_i.mterm)) + $signed(25'(d_i.day)) +
                $signed(25'(JD_EPOCH_OFFSET)) + corr;
    d_nxt.tod = d_i.ns_sec + 47'(d_i.ns) + NS_HALF_DAY;
    d_nxt.status = d_i.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && vld_i) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== sv/cjd_norm.sv =====
// ----------------------------------------------------------------------------
// cjd_norm: last pipeline stage and output register
// Carries a time of day past one whole day into the day count, and clears
// the result of a transaction with a field error.
// ----------------------------------------------------------------------------
module cjd_norm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ld,
  input  logic          vld_i,
  input  cjd_pkg::s3_t  d_i,
  output logic          vld_r,
  output cjd_pkg::out_t d_r
);
  import cjd_pkg::*;

  out_t d_nxt;
  logic wrap;

  always_comb begin
    wrap  = (d_i.tod >= NS_PER_DAY);
    d_nxt = '0;
    d_nxt.status = d_i.status;
    if (d_i.status == ST_OK) begin
      d_nxt.julian_day_number = 24'(wrap ? d_i.jdn + 25'sd1 : d_i.jdn);
      d_nxt.day_nanoseconds   = wrap ? d_i.tod - NS_PER_DAY : d_i.tod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && vld_i) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== sv/calendar_to_julian_day.sv =====
// ----------------------------------------------------------------------------
// calendar_to_julian_day: calendar date and time of day to Julian day
// Four-stage pipeline that converts a date and time into a whole Julian day
// number and the nanoseconds elapsed since the noon that starts that day.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while in_stall is low. Its
// result passes the decode, multiplication and sum registers in turn and is
// then loaded into the output register for the consumer to take. The
// four register stages are field decode and month lookup, the constant
// multiplications, the sums, and the day wrap with the output register.
// January and February count as months 13 and 14 of the previous year, and
// dates from 15 October 1582 onwards get the Gregorian correction. A field
// outside its range (a day only when it is zero) gives the status code of
// the first failing field (month, day, hour, minute, second, nanosecond)
// with a zero day number and zero nanoseconds. Each stage holds its own
// valid bit and loads whenever it is empty or the stage after it moves, so
// a stall on the result side only stops the stages that are full and empty
// stages ahead of it still take new transactions. The block holds no state
// between transactions and needs no configuration.
// ----------------------------------------------------------------------------
module calendar_to_julian_day (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cjd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cjd_pkg::out_t out_data
);
  import cjd_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  s1_t  s1;
  s2_t  s2;
  s3_t  s3;

  // A stage may load when it is empty or its content moves on in the same
  // cycle.
  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  cjd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (rdy1),
    .vld_i (in_valid),
    .d_i   (in_data),
    .vld_r (v1),
    .d_r   (s1)
  );

  cjd_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (rdy2),
    .vld_i (v1),
    .d_i   (s1),
    .vld_r (v2),
    .d_r   (s2)
  );

  cjd_sum u_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (rdy3),
    .vld_i (v2),
    .d_i   (s2),
    .vld_r (v3),
    .d_r   (s3)
  );

  cjd_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (rdy4),
    .vld_i (v3),
    .d_i   (s3),
    .vld_r (out_valid),
    .d_r   (out_data)
  );

endmodule

// ===== sv/cjd_checker.sv =====
// ----------------------------------------------------------------------------
// cjd_checker: port-level checks for calendar_to_julian_day
// Watches the ports of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module cjd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input cjd_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input cjd_pkg::out_t out_data
);
  import cjd_pkg::*;

  // A result held back by the consumer stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A transaction held back by the block stays in place at the input.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transaction changed");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The time of day lies within one day, the status is a known code, and an
  // error status comes with zero outputs.
  a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.day_nanoseconds < NS_PER_DAY && out_data.status <= ST_NANO &&
      (out_data.status == ST_OK ||
       (out_data.julian_day_number == 24'sd0 && out_data.day_nanoseconds == 47'd0)))
    else $error("result fields out of range");

  // With the output register free, the input never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind calendar_to_julian_day cjd_checker u_cjd_checker (.*);
